[src/lac_pkg.sv]
package lac_pkg;

    localparam int MAX_SAMPLES = 4096;

    localparam int PRICE_W = 24;
    localparam int CNT_W   = 13;
    localparam int PAIR_W  = 12;
    localparam int RET_W   = 25;
    localparam int PROD_W  = 50;
    localparam int SUM_W   = 37;
    localparam int SQ_W    = 62;
    localparam int MW      = 76;
    localparam int PW      = 2 * MW;
    localparam int VW      = 78;
    localparam int SCALE   = 60;
    localparam int RW      = PW + SCALE;
    localparam int DQ_W    = SCALE + 1;
    localparam int RT_W    = 62;
    localparam int Q_W     = 31;
    localparam int DCNT_W  = 6;

    // final multiply sequence, issued in this order
    localparam logic [2:0] OP_NXX = 3'd0;
    localparam logic [2:0] OP_SXX = 3'd1;
    localparam logic [2:0] OP_NYY = 3'd2;
    localparam logic [2:0] OP_SYY = 3'd3;
    localparam logic [2:0] OP_NXY = 3'd4;
    localparam logic [2:0] OP_SXY = 3'd5;
    localparam logic [2:0] OP_AB  = 3'd6;
    localparam logic [2:0] OP_NN  = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FEW   = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;
    localparam logic [1:0] ST_OVER  = 2'd3;

    typedef struct packed {
        logic signed [23:0] price_q;
        logic               last_sample;
    } lac_in_t;

    typedef struct packed {
        logic signed [31:0] correlation;
        logic [11:0]        pair_count;
        logic [1:0]         status;
    } lac_out_t;

    typedef struct packed {
        logic       load;
        logic       mult;
        logic       acc;
        logic       mstart;
        logic       mstore;
        logic [2:0] op;
        logic       dstart;
        logic       sstart;
        logic       emit;
    } lac_cmd_t;

    typedef struct packed {
        logic last;
        logic early;
        logic var_bad;
        logic mul_busy;
        logic div_busy;
        logic sqrt_busy;
        logic out_free;
    } lac_stat_t;

endpackage

[src/return_lag1_autocorrelation.sv]
// lag-1 autocorrelation of returns over a series of log-price samples
//
// sample channel: one signed Q5.18 log price per item plus a last flag.
// each accepted item passes the return, products and sums steps in turn, and
// sample_stall is high after every accepted item until its sums are added.
// result channel: one item per series, written on the last sample: pearson
// correlation as Q1.30, pair count and status code.
// after a last sample the block evaluates the result with one shift-add
// multiplier (eight products of up to 76 bits, one multiplier bit a cycle),
// a 61-step restoring divider and a 31-step square root; series with too
// few samples or overflow skip this evaluation, and zero variance ends it
// before the cross terms. input is stalled during that time.
// the result sits in an output register; a new series may start while it
// waits, and only the next result waits on result_stall.
// reset clears the running sums and the output valid; no clearing pass.
module return_lag1_autocorrelation (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  lac_pkg::lac_in_t  sample,
    output logic              result_valid,
    input  logic              result_stall,
    output lac_pkg::lac_out_t result
);
    import lac_pkg::*;

    lac_cmd_t  cmd;
    lac_stat_t stat;

    lac_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    lac_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .sample       (sample),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

[src/lac_mul.sv]
module lac_mul (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [lac_pkg::MW-1:0] a,
    input  logic [lac_pkg::MW-1:0] b,
    output logic                   busy,
    output logic [lac_pkg::PW-1:0] prod
);
    import lac_pkg::*;

    logic          busy_reg;
    logic [PW-1:0] acc_reg;
    logic [PW-1:0] mc_reg;
    logic [MW-1:0] mp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (busy_reg && mp_reg == '0)
        begin
            busy_reg <= 1'b0;
        end
    end

    // shift-add, one multiplier bit per cycle, stops once the rest is zero
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            mc_reg  <= PW'(a);
            mp_reg  <= b;
        end
        else if (busy_reg && mp_reg != '0)
        begin
            if (mp_reg[0])
            begin
                acc_reg <= acc_reg + mc_reg;
            end
            mc_reg <= mc_reg << 1;
            mp_reg <= mp_reg >> 1;
        end
    end

    assign busy = busy_reg;
    assign prod = acc_reg;

endmodule

[src/lac_ctrl.sv]
module lac_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_stall,
    input  lac_pkg::lac_stat_t stat,
    output lac_pkg::lac_cmd_t  cmd
);
    import lac_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL    = 4'd1;
    localparam logic [3:0] S_ACC    = 4'd2;
    localparam logic [3:0] S_MSTART = 4'd3;
    localparam logic [3:0] S_MWAIT  = 4'd4;
    localparam logic [3:0] S_DSTART = 4'd5;
    localparam logic [3:0] S_DWAIT  = 4'd6;
    localparam logic [3:0] S_SSTART = 4'd7;
    localparam logic [3:0] S_SWAIT  = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [2:0] op_reg;
    logic [2:0] op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_NXX;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        cmd.op     = op_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mult   = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
                if (!stat.last)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.early)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    op_next    = OP_NXX;
                    state_next = S_MSTART;
                end
            end
            S_MSTART:
            begin
                // both variances are known before the cross terms start
                if (op_reg == OP_NXY && stat.var_bad)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.mstart = 1'b1;
                    state_next = S_MWAIT;
                end
            end
            S_MWAIT:
            begin
                if (!stat.mul_busy)
                begin
                    cmd.mstore = 1'b1;
                    if (op_reg == OP_NN)
                    begin
                        state_next = S_DSTART;
                    end
                    else
                    begin
                        op_next    = op_reg + 3'd1;
                        state_next = S_MSTART;
                    end
                end
            end
            S_DSTART:
            begin
                cmd.dstart = 1'b1;
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_SSTART;
                end
            end
            S_SSTART:
            begin
                cmd.sstart = 1'b1;
                state_next = S_SWAIT;
            end
            S_SWAIT:
            begin
                if (!stat.sqrt_busy)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign sample_stall = (state_reg != S_IDLE);

`ifndef NO_ASSERTIONS
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result written over an item not yet taken");

    a_mstart_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mstart |-> !stat.mul_busy)
        else $error("multiply started while multiplier busy");

    a_load_mult: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.mult)
        else $error("accepted item not followed by its products");

    a_store_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mstart |=> !cmd.mstore || $past(cmd.op) == cmd.op)
        else $error("multiply result stored under another operation");
`endif

endmodule

[src/lac_dp.sv]
module lac_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  lac_pkg::lac_cmd_t  cmd,
    output lac_pkg::lac_stat_t stat,
    input  lac_pkg::lac_in_t   sample,
    input  logic               result_stall,
    output logic               result_valid,
    output lac_pkg::lac_out_t  result
);
    import lac_pkg::*;

    // series state
    logic signed [PRICE_W-1:0] prev_price_reg;
    logic signed [RET_W-1:0]   prev_ret_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      ovf_reg;
    logic                      last_reg;
    logic                      pair_en_reg;
    logic signed [SUM_W-1:0]   sx_reg;
    logic signed [SUM_W-1:0]   sy_reg;
    logic signed [SQ_W-1:0]    sxy_reg;
    logic signed [SQ_W-1:0]    sxx_reg;
    logic signed [SQ_W-1:0]    syy_reg;

    logic signed [RET_W-1:0]   x_reg;
    logic signed [RET_W-1:0]   y_reg;
    logic signed [PROD_W-1:0]  pxy_reg;
    logic signed [PROD_W-1:0]  pxx_reg;
    logic signed [PROD_W-1:0]  pyy_reg;

    // final evaluation
    logic signed [VW-1:0]      t_reg;
    logic signed [VW-1:0]      va_reg;
    logic signed [VW-1:0]      vb_reg;
    logic signed [VW-1:0]      num_reg;
    logic [PW-1:0]             ab_reg;
    logic [PW-1:0]             nn_reg;

    logic                      div_busy_reg;
    logic [DCNT_W-1:0]         dcnt_reg;
    logic [RW-1:0]             rem_reg;
    logic [RW-1:0]             dv_reg;
    logic [DQ_W-1:0]           quo_reg;

    logic                      sqrt_busy_reg;
    logic [RT_W-1:0]           sr_reg;
    logic [RT_W-1:0]           res_reg;
    logic [RT_W-1:0]           bit_reg;

    logic                      result_valid_reg;
    lac_out_t                  result_reg;

    logic signed [RET_W-1:0]   ret;
    logic [PAIR_W-1:0]         pairs;
    logic [SUM_W-1:0]          sx_mag;
    logic [SUM_W-1:0]          sy_mag;
    logic [SQ_W-1:0]           sxy_mag;
    logic [MW-1:0]             num_mag;
    logic [MW-1:0]             mul_a;
    logic [MW-1:0]             mul_b;
    logic                      mul_busy;
    logic [PW-1:0]             prod;
    logic signed [VW-1:0]      prod_s;
    logic                      div_ge;
    logic [RT_W-1:0]           trial;
    logic [1:0]                status_code;
    logic [31:0]               q_ext;

    assign ret     = RET_W'(sample.price_q) - RET_W'(prev_price_reg);
    assign pairs   = (cnt_reg >= CNT_W'(2)) ? PAIR_W'(cnt_reg - CNT_W'(2)) : '0;
    assign sx_mag  = sx_reg[SUM_W-1] ? SUM_W'(-sx_reg) : SUM_W'(sx_reg);
    assign sy_mag  = sy_reg[SUM_W-1] ? SUM_W'(-sy_reg) : SUM_W'(sy_reg);
    assign sxy_mag = sxy_reg[SQ_W-1] ? SQ_W'(-sxy_reg) : SQ_W'(sxy_reg);
    assign num_mag = num_reg[VW-1] ? MW'(-num_reg) : MW'(num_reg);
    assign prod_s  = $signed({1'b0, prod[VW-2:0]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_price_reg <= '0;
            prev_ret_reg   <= '0;
            cnt_reg        <= '0;
            ovf_reg        <= 1'b0;
            sx_reg         <= '0;
            sy_reg         <= '0;
            sxy_reg        <= '0;
            sxx_reg        <= '0;
            syy_reg        <= '0;
        end
        else if (cmd.emit)
        begin
            prev_price_reg <= '0;
            prev_ret_reg   <= '0;
            cnt_reg        <= '0;
            ovf_reg        <= 1'b0;
            sx_reg         <= '0;
            sy_reg         <= '0;
            sxy_reg        <= '0;
            sxx_reg        <= '0;
            syy_reg        <= '0;
        end
        else if (cmd.load)
        begin
            if (cnt_reg >= CNT_W'(MAX_SAMPLES))
            begin
                ovf_reg <= 1'b1;
            end
            else
            begin
                if (cnt_reg >= CNT_W'(1))
                begin
                    prev_ret_reg <= ret;
                end
                prev_price_reg <= sample.price_q;
                cnt_reg        <= cnt_reg + CNT_W'(1);
            end
        end
        else if (cmd.acc && pair_en_reg)
        begin
            sx_reg  <= sx_reg + SUM_W'(x_reg);
            sy_reg  <= sy_reg + SUM_W'(y_reg);
            sxy_reg <= sxy_reg + SQ_W'(pxy_reg);
            sxx_reg <= sxx_reg + SQ_W'(pxx_reg);
            syy_reg <= syy_reg + SQ_W'(pyy_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg       <= prev_ret_reg;
            y_reg       <= ret;
            last_reg    <= sample.last_sample;
            pair_en_reg <= (cnt_reg < CNT_W'(MAX_SAMPLES)) && (cnt_reg >= CNT_W'(2));
        end
        if (cmd.mult)
        begin
            pxy_reg <= x_reg * y_reg;
            pxx_reg <= x_reg * x_reg;
            pyy_reg <= y_reg * y_reg;
        end
    end

    always_comb
    begin
        unique case (cmd.op)
            OP_NXX:
            begin
                mul_a = MW'(sxx_reg[SQ_W-1:0]);
                mul_b = MW'(pairs);
            end
            OP_SXX:
            begin
                mul_a = MW'(sx_mag);
                mul_b = MW'(sx_mag);
            end
            OP_NYY:
            begin
                mul_a = MW'(syy_reg[SQ_W-1:0]);
                mul_b = MW'(pairs);
            end
            OP_SYY:
            begin
                mul_a = MW'(sy_mag);
                mul_b = MW'(sy_mag);
            end
            OP_NXY:
            begin
                mul_a = MW'(sxy_mag);
                mul_b = MW'(pairs);
            end
            OP_SXY:
            begin
                mul_a = MW'(sx_mag);
                mul_b = MW'(sy_mag);
            end
            OP_AB:
            begin
                mul_a = va_reg[MW-1:0];
                mul_b = vb_reg[MW-1:0];
            end
            OP_NN:
            begin
                mul_a = num_mag;
                mul_b = num_mag;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    lac_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mstart),
        .a     (mul_a),
        .b     (mul_b),
        .busy  (mul_busy),
        .prod  (prod)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.mstore)
        begin
            unique case (cmd.op) inside
                OP_NXX, OP_NYY:
                begin
                    t_reg <= prod_s;
                end
                OP_SXX:
                begin
                    va_reg <= t_reg - prod_s;
                end
                OP_SYY:
                begin
                    vb_reg <= t_reg - prod_s;
                end
                OP_NXY:
                begin
                    t_reg <= sxy_reg[SQ_W-1] ? -prod_s : prod_s;
                end
                OP_SXY:
                begin
                    num_reg <= t_reg - ((sx_reg[SUM_W-1] ^ sy_reg[SUM_W-1]) ? -prod_s : prod_s);
                end
                OP_AB:
                begin
                    ab_reg <= prod;
                end
                OP_NN:
                begin
                    nn_reg <= prod;
                end
                default:
                begin
                    t_reg <= t_reg;
                end
            endcase
        end
    end

    // restoring division: num^2 * 2^60 / (va * vb), quotient fits 61 bits
    assign div_ge = (rem_reg >= dv_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
        end
        else if (cmd.dstart)
        begin
            div_busy_reg <= 1'b1;
        end
        else if (div_busy_reg && dcnt_reg == '0)
        begin
            div_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.dstart)
        begin
            rem_reg  <= {nn_reg, {SCALE{1'b0}}};
            dv_reg   <= {ab_reg, {SCALE{1'b0}}};
            quo_reg  <= '0;
            dcnt_reg <= DCNT_W'(SCALE);
        end
        else if (div_busy_reg)
        begin
            if (div_ge)
            begin
                rem_reg <= rem_reg - dv_reg;
            end
            quo_reg  <= {quo_reg[DQ_W-2:0], div_ge};
            dv_reg   <= dv_reg >> 1;
            dcnt_reg <= dcnt_reg - DCNT_W'(1);
        end
    end

    // digit-by-digit integer square root of the quotient
    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sqrt_busy_reg <= 1'b0;
        end
        else if (cmd.sstart)
        begin
            sqrt_busy_reg <= 1'b1;
        end
        else if (sqrt_busy_reg && bit_reg[0])
        begin
            sqrt_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sstart)
        begin
            sr_reg  <= RT_W'(quo_reg);
            res_reg <= '0;
            bit_reg <= RT_W'(1) << SCALE;
        end
        else if (sqrt_busy_reg)
        begin
            if (sr_reg >= trial)
            begin
                sr_reg  <= sr_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    always_comb
    begin
        if (ovf_reg)
        begin
            status_code = ST_OVER;
        end
        else if (pairs == '0)
        begin
            status_code = ST_FEW;
        end
        else if (va_reg <= 0 || vb_reg <= 0)
        begin
            status_code = ST_ZERO;
        end
        else
        begin
            status_code = ST_OK;
        end
    end

    assign q_ext = 32'(res_reg[Q_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg.pair_count <= pairs;
            result_reg.status     <= status_code;
            if (status_code == ST_OK)
            begin
                result_reg.correlation <= num_reg[VW-1] ? -$signed(q_ext) : $signed(q_ext);
            end
            else
            begin
                result_reg.correlation <= '0;
            end
        end
    end

    assign stat.last      = last_reg;
    assign stat.early     = ovf_reg || (pairs == '0);
    assign stat.var_bad   = (va_reg <= 0) || (vb_reg <= 0);
    assign stat.mul_busy  = mul_busy;
    assign stat.div_busy  = div_busy_reg;
    assign stat.sqrt_busy = sqrt_busy_reg;
    assign stat.out_free  = !result_valid_reg || !result_stall;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import lac_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic     clk;
    logic     rst_n;
    logic     sample_valid;
    logic     sample_stall;
    lac_in_t  sample;
    logic     result_valid;
    logic     result_stall;
    lac_out_t result;

    return_lag1_autocorrelation dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // running series state of the predictor
    logic signed [23:0]  prev_price;
    logic signed [24:0]  prev_ret;
    int unsigned         n_samples;
    logic signed [63:0]  sx, sy, sxy, sxx, syy;
    bit                  overflowed;

    lac_out_t expected_results[$];
    int       error_count;
    int       idle_cycles;
    bit       stall_heavy;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    task automatic clear_series();
        prev_price = '0;
        prev_ret   = '0;
        n_samples  = 0;
        sx = '0; sy = '0; sxy = '0; sxx = '0; syy = '0;
        overflowed = 1'b0;
    endtask

    // largest q in [0, 2^31 - 1] with q^2 * va * vb <= num^2 * 2^60
    function automatic logic [30:0] pearson_q(input logic [159:0] num,
                                              input logic [159:0] va,
                                              input logic [159:0] vb);
        logic [511:0] ab;
        logic [511:0] rhs;
        logic [511:0] lhs;
        logic [30:0]  q;
        logic [30:0]  c;
        ab  = 512'(va) * 512'(vb);
        rhs = (512'(num) * 512'(num)) << 60;
        q = '0;
        for (int b = 30; b >= 0; b--)
        begin
            c = q | (31'd1 << b);
            lhs = 512'(64'(c) * 64'(c)) * ab;
            if (lhs <= rhs)
                q = c;
        end
        return q;
    endfunction

    task automatic predict_sample(input lac_in_t it);
        logic signed [24:0]  r;
        logic signed [159:0] n, va, vb, num;
        lac_out_t            o;
        logic [30:0]         q;
        int unsigned         pairs;
        if (n_samples >= MAX_SAMPLES)
            overflowed = 1'b1;
        else
        begin
            if (n_samples >= 1)
            begin
                r = 25'(it.price_q) - 25'(prev_price);
                if (n_samples >= 2)
                begin
                    sx  += 64'(prev_ret);
                    sy  += 64'(r);
                    sxy += 64'(prev_ret) * 64'(r);
                    sxx += 64'(prev_ret) * 64'(prev_ret);
                    syy += 64'(r) * 64'(r);
                end
                prev_ret = r;
            end
            prev_price = it.price_q;
            n_samples++;
        end
        if (!it.last_sample)
            return;
        pairs = n_samples >= 2 ? n_samples - 2 : 0;
        o.correlation = '0;
        o.pair_count  = 12'(pairs);
        if (overflowed)
            o.status = ST_OVER;
        else if (pairs < 1)
            o.status = ST_FEW;
        else
        begin
            n  = 160'(pairs);
            va = n * 160'(sxx) - 160'(sx) * 160'(sx);
            vb = n * 160'(syy) - 160'(sy) * 160'(sy);
            if (va <= 0 || vb <= 0)
                o.status = ST_ZERO;
            else
            begin
                o.status = ST_OK;
                num = n * 160'(sxy) - 160'(sx) * 160'(sy);
                q = pearson_q(num < 0 ? -num : num, va, vb);
                o.correlation = num < 0 ? -32'(q) : 32'(q);
            end
        end
        expected_results.insert(expected_results.size(), o);
        clear_series();
    endtask

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // valid stays high into the next item when there is no gap
    task automatic send_sample(input logic signed [23:0] price, input bit last);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            sample_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= '{price_q: price, last_sample: last};
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        predict_sample('{price_q: price, last_sample: last});
    endtask

    // result side stall and checker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall_heavy)
                result_stall <= ($urandom_range(0, 99) < 70);
            else
                result_stall <= ($urandom_range(0, 99) < 15);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
                report($sformatf("unexpected result %p", result));
            else
            begin
                lac_out_t e;
                e = expected_results.pop_front();
                if (result.correlation !== e.correlation)
                    report($sformatf("correlation %0d expected %0d",
                                     result.correlation, e.correlation));
                if (result.pair_count !== e.pair_count)
                    report($sformatf("pair_count %0d expected %0d",
                                     result.pair_count, e.pair_count));
                if (result.status !== e.status)
                    report($sformatf("status %0d expected %0d",
                                     result.status, e.status));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** return_lag1_autocorrelation: FAILED **");
            $finish;
        end
    end

    function automatic logic signed [23:0] rand_price();
        return 24'($urandom);
    endfunction

    task automatic send_series(input int len, input int mode);
        logic signed [23:0] p;
        logic signed [23:0] step;
        p = rand_price();
        step = 24'($signed($urandom_range(0, 2000)) - 1000);
        for (int i = 0; i < len; i++)
        begin
            case (mode)
                0: p = rand_price();
                1: p = p + step;
                2: p = p + 24'($signed($urandom_range(0, 200)) - 100);
                default: p = (i % 2) ? 24'sh7fffff : -24'sh800000;
            endcase
            send_sample(p, i == len - 1);
        end
    endtask

    task automatic test_directed();
        send_sample(24'sd5, 1'b1);
        send_series(2, 0);
        send_series(3, 0);
        send_series(4, 1);
        send_series(6, 3);
        send_sample(-24'sh800000, 1'b0);
        send_sample(24'sh7fffff, 1'b0);
        send_sample(-24'sh800000, 1'b0);
        send_sample(24'sh7fffff, 1'b0);
        send_sample(24'sd0, 1'b1);
        send_series(5, 0);
    endtask

    task automatic test_capacity();
        // overflow, with the ignored last sample ending the series
        send_series(MAX_SAMPLES + 1, 2);
    endtask

    task automatic test_random();
        int sent;
        int len;
        sent = 0;
        while (sent < 1900)
        begin
            stall_heavy = ($urandom_range(0, 3) == 0);
            len = $urandom_range(0, 9) == 0 ? $urandom_range(1, 3)
                                            : $urandom_range(4, 40);
            send_series(len, $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3));
            sent += len;
        end
        stall_heavy = 1'b0;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        result_stall = 1'b0;
        error_count  = 0;
        idle_cycles  = 0;
        stall_heavy  = 1'b0;
        clear_series();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_capacity();
        test_random();
        sample_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("** return_lag1_autocorrelation: PASSED **");
        else
            $display("** return_lag1_autocorrelation: FAILED **");
        $finish;
    end

endmodule

[sim.f]
src/lac_pkg.sv
src/lac_mul.sv
src/lac_ctrl.sv
src/lac_dp.sv
src/return_lag1_autocorrelation.sv
tb/tb.sv
